/* design/ffa_pkg.sv */
// Shared constants, codes and helpers of the first-fit free-list allocator.
`default_nettype none
package ffa_pkg;

  localparam int MEM_BYTES       = 16384;
  localparam int MAX_FREE_BLOCKS = 16;

  localparam int ADDR_W   = 14;
  localparam int NODE_W   = 7;
  localparam int STATUS_W = 2;
  localparam int MEM_AW   = $clog2(MEM_BYTES);
  localparam int IDX_W    = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int CNT_W    = $clog2(MAX_FREE_BLOCKS + 1);

  localparam logic [ADDR_W-1:0] HDR_BYTES      = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] ADDR_MAX       = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] HEAP_START_RST = ADDR_W'(5000);
  localparam logic [ADDR_W-1:0] HEAP_END_RST   = ADDR_W'(8000);
  localparam logic [ADDR_W-1:0] HEAP_SIZE_RST  = HEAP_END_RST - HEAP_START_RST;
  localparam logic [NODE_W-1:0] NODE_BYTES_RST = NODE_W'(32);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] REG_HEAP_START = 2'd0;
  localparam logic [1:0] REG_HEAP_END   = 2'd1;
  localparam logic [1:0] REG_NODE_BYTES = 2'd2;

  // Header store index of a byte address; MEM_BYTES is a power of two.
  function automatic logic [MEM_AW-1:0] hdr_index(input logic [ADDR_W-1:0] addr);
    logic [31:0] wide;
    wide = 32'(addr);
    return wide[MEM_AW-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/first_fit_free_list_allocator_top.sv */
// Top level of the first-fit free-list allocator with its sequencer and registers.
//
// Commands arrive on the slave stream: s_tuser selects allocate or free, s_tdata
// carries the request size and the release address. Each item produces exactly
// one result item on the master stream with the allocated address and a status.
// An allocation inspects one free-list entry per cycle through a single size
// compare, while no register write holds it. It takes the first entry that fits,
// at most the MAX_FREE_BLOCKS-th (16), and reports no fit when the list runs out.
// A free reads the size header from the header RAM and, if the block is large
// enough and the list is not full, shifts the list to put it at the head.
// s_tready returns when the state machine is back in idle after the result is
// loaded. A result waits in the output register while the receiver stalls,
// and the block already accepts the next item; that item's result is held back,
// with s_tready low, until the output register is free. s_tready is also low
// during a register write. Reset, and every write to the three defined APB
// registers, rebuild the free list as a single block spanning the configured
// heap bounds. Reset restores the register defaults; the header RAM is not
// cleared.
`default_nettype none
module first_fit_free_list_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: request_bytes [13:0], release_addr [27:14], zero [31:28]
  input  wire logic [31:0] s_tdata,
  // s_tuser: cmd [0]
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: block_addr [13:0], status [15:14]
  output logic      [15:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = ffa_pkg::ADDR_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FREE, S_DONE} state_t;

  state_t state;

  logic [AW-1:0]                heap_base;
  logic [AW-1:0]                heap_limit;
  logic [ffa_pkg::NODE_W-1:0]   node_bytes;
  logic [AW-1:0]                list_start [ffa_pkg::MAX_FREE_BLOCKS];
  logic [AW-1:0]                list_size  [ffa_pkg::MAX_FREE_BLOCKS];
  logic [ffa_pkg::CNT_W-1:0]    list_count;
  logic [ffa_pkg::CNT_W-1:0]    idx;
  logic [AW-1:0]                req;
  logic [AW-1:0]                base;
  logic [AW:0]                  need;
  logic [AW-1:0]                res_addr;
  logic [ffa_pkg::STATUS_W-1:0] res_status;

  logic                         cfg_we;
  logic [AW-1:0]                hs_new;
  logic [AW-1:0]                he_new;
  logic [AW-1:0]                in_req;
  logic [AW-1:0]                in_rel;
  logic [AW-1:0]                cur_start;
  logic [AW-1:0]                cur_len;
  logic                         in_range;
  logic                         fit;
  logic                         hdr_we;
  logic [AW-1:0]                hdr_rdata;
  logic [AW:0]                  total_wide;
  logic [AW-1:0]                total;
  logic                         res_load;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign s_tready = (state == S_IDLE) && !cfg_we;
  assign in_req   = s_tdata[13:0];
  assign in_rel   = s_tdata[27:14];
  assign res_load = (state == S_DONE) && !cfg_we && (!m_tvalid || m_tready);

  assign hs_new = (paddr[3:2] == ffa_pkg::REG_HEAP_START) ? pwdata[AW-1:0] : heap_base;
  assign he_new = (paddr[3:2] == ffa_pkg::REG_HEAP_END)   ? pwdata[AW-1:0] : heap_limit;

  assign cur_start = list_start[idx[ffa_pkg::IDX_W-1:0]];
  assign cur_len   = list_size[idx[ffa_pkg::IDX_W-1:0]];
  assign in_range  = (idx < list_count);
  assign fit       = ({1'b0, cur_len} >= need);
  assign hdr_we    = (state == S_WALK) && in_range && fit;

  assign total_wide = {1'b0, hdr_rdata} + {1'b0, ffa_pkg::HDR_BYTES};
  assign total      = total_wide[AW] ? ffa_pkg::ADDR_MAX : total_wide[AW-1:0];

  always_comb begin
    case (paddr[3:2])
      ffa_pkg::REG_HEAP_START: prdata = 32'(heap_base);
      ffa_pkg::REG_HEAP_END:   prdata = 32'(heap_limit);
      ffa_pkg::REG_NODE_BYTES: prdata = 32'(node_bytes);
      default:                 prdata = 32'd0;
    endcase
  end

  ffa_ram #(
    .WIDTH (AW),
    .DEPTH (ffa_pkg::MEM_BYTES)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (hdr_we),
    .wr_addr (ffa_pkg::hdr_index(cur_start)),
    .wr_data (req),
    .rd_addr (ffa_pkg::hdr_index(in_rel - ffa_pkg::HDR_BYTES)),
    .rd_data (hdr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      heap_base     <= ffa_pkg::HEAP_START_RST;
      heap_limit    <= ffa_pkg::HEAP_END_RST;
      node_bytes    <= ffa_pkg::NODE_BYTES_RST;
      list_start[0] <= ffa_pkg::HEAP_START_RST;
      list_size[0]  <= ffa_pkg::HEAP_SIZE_RST;
      list_count    <= ffa_pkg::CNT_W'(1);
      idx           <= '0;
    end else begin
      if (m_tvalid && m_tready && !res_load) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (paddr[3:2])
          ffa_pkg::REG_HEAP_START: heap_base  <= pwdata[AW-1:0];
          ffa_pkg::REG_HEAP_END:   heap_limit <= pwdata[AW-1:0];
          ffa_pkg::REG_NODE_BYTES: node_bytes <= pwdata[ffa_pkg::NODE_W-1:0];
          default: ;
        endcase
        if (paddr[3:2] inside {ffa_pkg::REG_HEAP_START, ffa_pkg::REG_HEAP_END,
                               ffa_pkg::REG_NODE_BYTES}) begin
          list_start[0] <= hs_new;
          list_size[0]  <= (he_new >= hs_new) ? (he_new - hs_new) : '0;
          list_count    <= ffa_pkg::CNT_W'(1);
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (s_tvalid && s_tready) begin
              req  <= in_req;
              base <= in_rel - ffa_pkg::HDR_BYTES;
              need <= {1'b0, in_req} + (AW+1)'(node_bytes) + {1'b0, ffa_pkg::HDR_BYTES};
              idx  <= '0;
              state <= (s_tuser == ffa_pkg::CMD_FREE) ? S_FREE : S_WALK;
            end
          end
          S_WALK: begin
            if (!in_range) begin
              res_addr   <= '0;
              res_status <= ffa_pkg::ST_NOFIT;
              state      <= S_DONE;
            end else if (fit) begin
              list_start[idx[ffa_pkg::IDX_W-1:0]] <= cur_start + req + ffa_pkg::HDR_BYTES;
              list_size[idx[ffa_pkg::IDX_W-1:0]]  <= cur_len - req - ffa_pkg::HDR_BYTES;
              res_addr   <= cur_start + ffa_pkg::HDR_BYTES;
              res_status <= ffa_pkg::ST_OK;
              state      <= S_DONE;
            end else begin
              idx <= idx + ffa_pkg::CNT_W'(1);
            end
          end
          S_FREE: begin
            res_addr <= '0;
            if (hdr_rdata < AW'(node_bytes)) begin
              res_status <= ffa_pkg::ST_SMALL;
            end else if (list_count >= ffa_pkg::CNT_W'(ffa_pkg::MAX_FREE_BLOCKS)) begin
              res_status <= ffa_pkg::ST_FULL;
            end else begin
              for (int k = ffa_pkg::MAX_FREE_BLOCKS - 1; k > 0; k--) begin
                list_start[k] <= list_start[k-1];
                list_size[k]  <= list_size[k-1];
              end
              list_start[0] <= base;
              list_size[0]  <= total;
              list_count    <= list_count + ffa_pkg::CNT_W'(1);
              res_status    <= ffa_pkg::ST_OK;
            end
            state <= S_DONE;
          end
          S_DONE: begin
            if (res_load) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {res_status, res_addr};
              state    <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* design/ffa_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the first-fit free-list allocator: directed table, then random phases.
module testbench;

  localparam int AW          = ffa_pkg::ADDR_W;
  localparam int SW          = ffa_pkg::STATUS_W;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int POOL_DEPTH  = 64;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [SW-1:0] status;
  } alloc_result_t;

  typedef struct {
    bit            is_write;
    logic          cmd;
    logic [AW-1:0] req;
    logic [AW-1:0] rel;
    logic [1:0]    reg_idx;
    logic [AW-1:0] reg_val;
    bit            typed;
    alloc_result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  first_fit_free_list_allocator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [AW-1:0]              cfg_base;
  logic [AW-1:0]              cfg_limit;
  logic [ffa_pkg::NODE_W-1:0] cfg_node;
  logic [AW-1:0]              free_start [ffa_pkg::MAX_FREE_BLOCKS];
  logic [AW-1:0]              free_size  [ffa_pkg::MAX_FREE_BLOCKS];
  int                         free_count;
  logic [AW-1:0]              hdr_mem [ffa_pkg::MEM_BYTES];

  alloc_result_t expected_results[$];
  logic [AW-1:0] live_addrs[$];
  plan_row_t     directed_plan[$];

  int error_count = 0;
  int idle_cycles = 0;
  bit quiet_phase;
  bit hold_request;
  bit input_offered;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void rebuild_free_list();
    free_start[0] = cfg_base;
    free_size[0]  = (cfg_limit >= cfg_base) ? cfg_limit - cfg_base : '0;
    free_count    = 1;
  endfunction

  function automatic alloc_result_t predict_allocator(logic cmd, logic [AW-1:0] req,
                                                      logic [AW-1:0] rel);
    alloc_result_t res;
    int            need;
    int            total;
    bit            found;
    logic [AW-1:0] s;
    logic [AW-1:0] base;
    logic [AW-1:0] sz;
    res.addr   = '0;
    res.status = ffa_pkg::ST_OK;
    found      = 1'b0;
    if (cmd == ffa_pkg::CMD_ALLOC) begin
      need = int'(req) + int'(cfg_node) + int'(ffa_pkg::HDR_BYTES);
      for (int i = 0; i < free_count; i++) begin
        if (!found && int'(free_size[i]) >= need) begin
          s             = free_start[i];
          hdr_mem[s]    = req;
          res.addr      = s + ffa_pkg::HDR_BYTES;
          free_start[i] = s + req + ffa_pkg::HDR_BYTES;
          free_size[i]  = free_size[i] - req - ffa_pkg::HDR_BYTES;
          found         = 1'b1;
        end
      end
      if (!found) begin
        res.status = ffa_pkg::ST_NOFIT;
      end
    end else begin
      base = rel - ffa_pkg::HDR_BYTES;
      sz   = hdr_mem[base];
      if (sz < cfg_node) begin
        res.status = ffa_pkg::ST_SMALL;
      end else if (free_count >= ffa_pkg::MAX_FREE_BLOCKS) begin
        res.status = ffa_pkg::ST_FULL;
      end else begin
        total = int'(sz) + int'(ffa_pkg::HDR_BYTES);
        if (total > int'(ffa_pkg::ADDR_MAX)) begin
          total = int'(ffa_pkg::ADDR_MAX);
        end
        for (int i = free_count; i > 0; i--) begin
          free_start[i] = free_start[i-1];
          free_size[i]  = free_size[i-1];
        end
        free_start[0] = base;
        free_size[0]  = AW'(total);
        free_count++;
      end
    end
    return res;
  endfunction

  function automatic void add_item(logic cmd, logic [AW-1:0] req, logic [AW-1:0] rel);
    plan_row_t row;
    row          = '{default: '0};
    row.cmd      = cmd;
    row.req      = req;
    row.rel      = rel;
    directed_plan.push_back(row);
  endfunction

  function automatic void add_checked(logic cmd, logic [AW-1:0] req, logic [AW-1:0] rel,
                                      logic [AW-1:0] addr, logic [SW-1:0] status);
    plan_row_t row;
    row             = '{default: '0};
    row.cmd         = cmd;
    row.req         = req;
    row.rel         = rel;
    row.typed       = 1'b1;
    row.want.addr   = addr;
    row.want.status = status;
    directed_plan.push_back(row);
  endfunction

  function automatic void add_write(logic [1:0] idx, logic [AW-1:0] value);
    plan_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = value;
    directed_plan.push_back(row);
  endfunction

  function automatic int draw_sink_wait();
    if (hold_request) begin
      hold_request = 1'b0;
      return LONG_HOLD;
    end
    return quiet_phase ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic wait_all_results();
    if (input_offered) begin
      s_tvalid      <= 1'b0;
      input_offered = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(logic cmd, logic [AW-1:0] req, logic [AW-1:0] rel,
                           bit typed, alloc_result_t want);
    int            gap;
    alloc_result_t predicted;
    gap = quiet_phase ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      if (input_offered) s_tvalid <= 1'b0;
      input_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid      <= 1'b1;
    s_tuser       <= cmd;
    s_tdata       <= {4'b0000, rel, req};
    input_offered = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_allocator(cmd, req, rel);
    expected_results.push_back(typed ? want : predicted);
    if (cmd == ffa_pkg::CMD_ALLOC && predicted.status == ffa_pkg::ST_OK) begin
      live_addrs.push_back(predicted.addr);
      if (live_addrs.size() > POOL_DEPTH) void'(live_addrs.pop_front());
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [AW-1:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    wait_all_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel     <= 1'b0;
    penable  <= 1'b0;
    case (idx)
      ffa_pkg::REG_HEAP_START: begin
        cfg_base = value;
        want     = 32'(cfg_base);
      end
      ffa_pkg::REG_HEAP_END: begin
        cfg_limit = value;
        want      = 32'(cfg_limit);
      end
      default: begin
        cfg_node = value[ffa_pkg::NODE_W-1:0];
        want     = 32'(cfg_node);
      end
    endcase
    rebuild_free_list();
    if (readback !== want) begin
      error_count++;
      $display("%0t register %0d readback: expected %0d, actual %0d", $time, idx, want, readback);
    end
    @(posedge clk);
  endtask

  initial begin : result_sink
    alloc_result_t want;
    int            wait_left;
    m_tready  <= 1'b0;
    wait_left = $urandom_range(0, 9);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t unexpected result item: expected none, actual %h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[AW-1:0] !== want.addr) begin
            error_count++;
            $display("%0t block_addr mismatch: expected %0d, actual %0d", $time, want.addr,
                     m_tdata[AW-1:0]);
          end
          if (m_tdata[AW +: SW] !== want.status) begin
            error_count++;
            $display("%0t status mismatch: expected %0d, actual %0d", $time, want.status,
                     m_tdata[AW +: SW]);
          end
        end
        wait_left = draw_sink_wait();
        if (wait_left != 0) m_tready <= 1'b0;
      end else if (!m_tready) begin
        if (wait_left > 0) wait_left--;
        if (wait_left == 0) m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stimulus
    logic          cmd;
    logic [AW-1:0] req;
    logic [AW-1:0] rel;
    int            lo;
    int            hi;
    alloc_result_t none;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    none        = '0;
    quiet_phase   = 1'b0;
    hold_request  = 1'b0;
    input_offered = 1'b0;
    cfg_base  = ffa_pkg::HEAP_START_RST;
    cfg_limit = ffa_pkg::HEAP_END_RST;
    cfg_node  = ffa_pkg::NODE_BYTES_RST;
    rebuild_free_list();

    add_checked(ffa_pkg::CMD_ALLOC, 0, 0, ffa_pkg::HEAP_START_RST + ffa_pkg::HDR_BYTES,
                ffa_pkg::ST_OK);
    add_checked(ffa_pkg::CMD_FREE, 0, ffa_pkg::HEAP_START_RST + ffa_pkg::HDR_BYTES, 0,
                ffa_pkg::ST_SMALL);
    add_checked(ffa_pkg::CMD_ALLOC, ffa_pkg::ADDR_MAX, 0, 0, ffa_pkg::ST_NOFIT);
    add_item(ffa_pkg::CMD_ALLOC, 40, 0);
    repeat (ffa_pkg::MAX_FREE_BLOCKS - 1) add_item(ffa_pkg::CMD_FREE, 0, 5008);
    add_checked(ffa_pkg::CMD_FREE, 0, 5008, 0, ffa_pkg::ST_FULL);
    add_write(ffa_pkg::REG_HEAP_START, 9000);
    add_checked(ffa_pkg::CMD_ALLOC, 0, 0, 0, ffa_pkg::ST_NOFIT);
    add_item(ffa_pkg::CMD_FREE, 0, 5008);
    add_item(ffa_pkg::CMD_ALLOC, 0, 0);
    add_write(ffa_pkg::REG_HEAP_START, 0);
    add_write(ffa_pkg::REG_HEAP_END, ffa_pkg::ADDR_MAX);
    add_write(ffa_pkg::REG_NODE_BYTES, 4);
    add_checked(ffa_pkg::CMD_ALLOC, 16375, 0, 4, ffa_pkg::ST_OK);
    add_checked(ffa_pkg::CMD_FREE, 0, 4, 0, ffa_pkg::ST_OK);
    add_write(ffa_pkg::REG_NODE_BYTES, 64);
    add_item(ffa_pkg::CMD_ALLOC, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_write)
        write_register(directed_plan[r].reg_idx, directed_plan[r].reg_val);
      else
        send_item(directed_plan[r].cmd, directed_plan[r].req, directed_plan[r].rel,
                  directed_plan[r].typed, directed_plan[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: begin
          write_register(ffa_pkg::REG_HEAP_START, 0);
          write_register(ffa_pkg::REG_HEAP_END, ffa_pkg::ADDR_MAX);
          write_register(ffa_pkg::REG_NODE_BYTES, 4);
        end
        2: begin
          write_register(ffa_pkg::REG_HEAP_START, AW'($urandom_range(0, 12000)));
          write_register(ffa_pkg::REG_HEAP_END, ffa_pkg::ADDR_MAX);
          write_register(ffa_pkg::REG_NODE_BYTES, 64);
        end
        6: begin
          write_register(ffa_pkg::REG_HEAP_START,
                         AW'($urandom_range(9000, int'(ffa_pkg::ADDR_MAX))));
          write_register(ffa_pkg::REG_HEAP_END, AW'($urandom_range(0, 8000)));
        end
        default: begin
          lo = $urandom_range(0, 14000);
          hi = lo + $urandom_range(200, 5000);
          if (hi > int'(ffa_pkg::ADDR_MAX)) hi = int'(ffa_pkg::ADDR_MAX);
          write_register(ffa_pkg::REG_HEAP_START, AW'(lo));
          write_register(ffa_pkg::REG_HEAP_END, AW'(hi));
          if ($urandom_range(0, 1) == 1)
            write_register(ffa_pkg::REG_NODE_BYTES, AW'($urandom_range(4, 64)));
        end
      endcase
      quiet_phase  = (p % 4 == 3);
      hold_request = (p == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == PHASE_ITEMS / 2) wait_all_results();
        if (live_addrs.size() == 0 || $urandom_range(0, 99) < 55) begin
          cmd = ffa_pkg::CMD_ALLOC;
          req = ($urandom_range(0, 9) == 0) ? AW'($urandom) : AW'($urandom_range(0, 200));
          rel = AW'($urandom);
        end else begin
          cmd = ffa_pkg::CMD_FREE;
          req = AW'($urandom);
          rel = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        end
        send_item(cmd, req, rel, 1'b0, none);
      end
    end

    wait_all_results();
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
design/ffa_pkg.sv
design/ffa_ram.sv
design/first_fit_free_list_allocator_top.sv
test/testbench.sv
